>>> src/omt_pkg.sv
// omt_pkg: shared constants, codes and record types of the order message translator
// used by omt_front, omt_queue, omt_back and the top level; depends on nothing
`default_nettype none
package omt_pkg;
	localparam int ORDER_SLOTS = 1024;
	localparam int SLOT_W = $clog2(ORDER_SLOTS);
	localparam int FILL_W = $clog2(ORDER_SLOTS + 1);
	localparam int MSG_BYTES = 34;
	localparam int OUT_BYTES = 48;
	localparam int CNT_W = 6;

	localparam logic [7:0] TYPE_ADD = 8'h41;
	localparam logic [7:0] TYPE_EXEC = 8'h45;
	localparam logic [7:0] TYPE_RED = 8'h58;
	localparam logic [7:0] TYPE_REPL = 8'h52;
	localparam logic [7:0] ASCII_SPACE = 8'h20;

	localparam logic [CNT_W-1:0] LEN_ADD = 6'd34;
	localparam logic [CNT_W-1:0] LEN_EXEC = 6'd21;
	localparam logic [CNT_W-1:0] LEN_RED = 6'd21;
	localparam logic [CNT_W-1:0] LEN_REPL = 6'd33;

	localparam logic [7:0] OUT_TYPE_ADD = 8'd1;
	localparam logic [7:0] OUT_TYPE_EXEC = 8'd2;
	localparam logic [7:0] OUT_TYPE_RED = 8'd3;
	localparam logic [7:0] OUT_TYPE_REPL = 8'd4;
	localparam logic [7:0] SIZE_ADD = 8'h2C;
	localparam logic [7:0] SIZE_EXEC = 8'h28;
	localparam logic [7:0] SIZE_RED = 8'h20;
	localparam logic [7:0] SIZE_REPL = 8'h30;

	localparam logic [10:0] EXP_BIAS = 11'd1023;

	typedef enum logic [2:0] {
		KIND_ADD,
		KIND_EXEC,
		KIND_RED,
		KIND_REPL,
		KIND_BAD
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_BAD_TYPE = 2'd1,
		ST_NO_ORDER = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef logic [MSG_BYTES-1:0][7:0] msg_bytes_t;

	typedef struct packed {
		kind_t kind;
		msg_bytes_t bytes;
	} msg_t;

	typedef struct packed {
		logic [63:0] key;
		logic [63:0] sym;
		logic [31:0] shares;
		logic [31:0] price;
	} row_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;
endpackage
`default_nettype wire

>>> src/omt_ifs.sv
// omt_ifs: request channels of the order message translator (input bytes, output
// bytes, configuration write); no dependencies
`default_nettype none
interface omt_byte_if;
	logic valid;
	logic ready;
	logic [7:0] in_byte;
	modport source(output valid, output in_byte, input ready);
	modport sink(input valid, input in_byte, output ready);
endinterface

interface omt_res_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic last;
	logic [1:0] status;
	modport source(output valid, output out_byte, output last, output status, input ready);
	modport sink(input valid, input out_byte, input last, input status, output ready);
endinterface

interface omt_cfg_if;
	logic valid;
	logic ready;
	logic [63:0] midnight_epoch_ns;
	modport source(output valid, output midnight_epoch_ns, input ready);
	modport sink(input valid, input midnight_epoch_ns, output ready);
endinterface
`default_nettype wire

>>> src/omt_front.sv
// omt_front: collects input bytes into messages and classifies them by type byte
// depends on omt_pkg and omt_ifs
`default_nettype none
module omt_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	omt_byte_if.sink            feed,
	input  omt_pkg::q_stat_t    q_stat,
	output logic                q_push,
	output omt_pkg::msg_t       q_msg
);
	omt_pkg::msg_bytes_t mbuf_q;
	omt_pkg::msg_bytes_t nbuf;
	logic [omt_pkg::CNT_W-1:0] cnt_q;
	logic [omt_pkg::CNT_W-1:0] need;
	omt_pkg::kind_t kind;
	logic known;
	logic acc;
	logic done;

	assign feed.ready = !q_stat.full;
	assign acc = feed.valid && feed.ready;

	always_comb begin
		nbuf = mbuf_q;
		nbuf[cnt_q] = feed.in_byte;
		known = 1'b1;
		unique case (nbuf[0])
			omt_pkg::TYPE_ADD: begin
				kind = omt_pkg::KIND_ADD;
				need = omt_pkg::LEN_ADD;
			end
			omt_pkg::TYPE_EXEC: begin
				kind = omt_pkg::KIND_EXEC;
				need = omt_pkg::LEN_EXEC;
			end
			omt_pkg::TYPE_RED: begin
				kind = omt_pkg::KIND_RED;
				need = omt_pkg::LEN_RED;
			end
			omt_pkg::TYPE_REPL: begin
				kind = omt_pkg::KIND_REPL;
				need = omt_pkg::LEN_REPL;
			end
			default: begin
				kind = omt_pkg::KIND_BAD;
				need = '0;
				known = 1'b0;
			end
		endcase
	end

	assign done = !known || (cnt_q + 6'd1 == need);
	assign q_push = acc && done;
	assign q_msg.kind = kind;
	assign q_msg.bytes = nbuf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (acc) begin
			cnt_q <= done ? '0 : cnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mbuf_q <= nbuf;
		end
	end
endmodule
`default_nettype wire

>>> src/omt_queue.sv
// omt_queue: two-entry message queue between front and back
// depends on omt_pkg
`default_nettype none
module omt_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  omt_pkg::msg_t    wr_msg,
	input  wire logic        pop,
	output omt_pkg::msg_t    rd_msg,
	output omt_pkg::q_stat_t stat
);
	omt_pkg::msg_t slot_q [2];
	logic wptr_q;
	logic rptr_q;
	logic [1:0] cnt_q;

	assign stat.full = cnt_q == 2'd2;
	assign stat.empty = cnt_q == 2'd0;
	assign rd_msg = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wr_msg;
		end
	end
endmodule
`default_nettype wire

>>> src/omt_back.sv
// omt_back: order table lookup and update, price conversion and output serializer
// depends on omt_pkg and omt_ifs
`default_nettype none
module omt_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [63:0] epoch,
	input  omt_pkg::q_stat_t q_stat,
	input  omt_pkg::msg_t    q_msg,
	output logic             q_pop,
	omt_res_if.source        xlat
);
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_NORM  = 5'b00100,
		S_BUILD = 5'b01000,
		S_SEND  = 5'b10000
	} state_t;

	function automatic logic [63:0] be64(omt_pkg::msg_bytes_t b, int off);
		logic [63:0] v;
		v = '0;
		for (int i = 0; i < 8; i++) v = {v[55:0], b[off + i]};
		return v;
	endfunction

	function automatic logic [31:0] be32(omt_pkg::msg_bytes_t b, int off);
		logic [31:0] v;
		v = '0;
		for (int i = 0; i < 4; i++) v = {v[23:0], b[off + i]};
		return v;
	endfunction

	state_t state_q;
	omt_pkg::msg_t msg_q;
	logic [omt_pkg::FILL_W-1:0] fill_q;
	logic [omt_pkg::FILL_W-1:0] scan_q;
	logic rd_v_s1;
	logic [omt_pkg::SLOT_W-1:0] rd_slot_s1;
	omt_pkg::row_t rd_row_s1;
	omt_pkg::row_t row_q;
	omt_pkg::row_t tbl_mem [omt_pkg::ORDER_SLOTS];
	omt_pkg::status_t err_q;
	logic [31:0] mag_q;
	logic [4:0] exp_q;
	logic sign_q;
	logic [omt_pkg::OUT_BYTES-1:0][7:0] ov_q;
	logic [omt_pkg::CNT_W-1:0] len_q;
	logic [omt_pkg::CNT_W-1:0] sent_q;
	logic out_v_q;
	logic [7:0] out_byte_q;
	logic out_last_q;
	omt_pkg::status_t out_st_q;

	logic [63:0] ref_key;
	logic match;
	logic miss;
	logic issue;
	logic decide;
	logic wr_en;
	logic [omt_pkg::SLOT_W-1:0] wr_slot;
	omt_pkg::row_t wr_row;
	logic grow;
	omt_pkg::status_t dec_err;
	logic [31:0] cvt_price;
	logic [63:0] sym;
	logic [63:0] dbl;
	logic [7:0] otype;
	logic [7:0] osize;
	logic [omt_pkg::OUT_BYTES-1:0][7:0] ov_new;
	logic load;

	assign ref_key = be64(msg_q.bytes, 9);
	assign match = rd_v_s1 && rd_row_s1.key == ref_key;
	assign miss = !match && !rd_v_s1 && scan_q == fill_q;
	assign issue = state_q == S_SCAN && !match && scan_q < fill_q;
	assign decide = state_q == S_SCAN && (match || miss);
	assign q_pop = state_q == S_IDLE && !q_stat.empty;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			sym[8*i +: 8] = msg_q.bytes[22 + i] == omt_pkg::ASCII_SPACE ?
				8'h00 : msg_q.bytes[22 + i];
		end
	end

	always_comb begin
		wr_en = 1'b0;
		wr_slot = rd_slot_s1;
		wr_row = rd_row_s1;
		grow = 1'b0;
		dec_err = omt_pkg::ST_OK;
		case (msg_q.kind)
			omt_pkg::KIND_ADD: begin
				wr_row = '{key: ref_key, sym: sym, shares: be32(msg_q.bytes, 18),
					price: be32(msg_q.bytes, 30)};
				if (match) begin
					wr_en = decide;
				end else if (fill_q < omt_pkg::FILL_W'(omt_pkg::ORDER_SLOTS)) begin
					wr_en = decide;
					grow = decide;
					wr_slot = fill_q[omt_pkg::SLOT_W-1:0];
				end else begin
					dec_err = omt_pkg::ST_FULL;
				end
			end
			omt_pkg::KIND_RED: begin
				wr_row.shares = rd_row_s1.shares - be32(msg_q.bytes, 17);
				wr_en = decide && match;
				if (!match) dec_err = omt_pkg::ST_NO_ORDER;
			end
			omt_pkg::KIND_REPL: begin
				wr_row.key = be64(msg_q.bytes, 17);
				wr_row.shares = be32(msg_q.bytes, 25);
				wr_row.price = be32(msg_q.bytes, 29);
				wr_en = decide && match;
				if (!match) dec_err = omt_pkg::ST_NO_ORDER;
			end
			default: begin
				if (!match) dec_err = omt_pkg::ST_NO_ORDER;
			end
		endcase
		cvt_price = wr_row.price;
	end

	assign dbl = mag_q == '0 ? 64'd0 :
		{sign_q, omt_pkg::EXP_BIAS + 11'(exp_q), mag_q[30:0], 21'd0};

	always_comb begin
		unique case (msg_q.kind)
			omt_pkg::KIND_ADD: begin
				otype = omt_pkg::OUT_TYPE_ADD;
				osize = omt_pkg::SIZE_ADD;
			end
			omt_pkg::KIND_EXEC: begin
				otype = omt_pkg::OUT_TYPE_EXEC;
				osize = omt_pkg::SIZE_EXEC;
			end
			omt_pkg::KIND_RED: begin
				otype = omt_pkg::OUT_TYPE_RED;
				osize = omt_pkg::SIZE_RED;
			end
			default: begin
				otype = omt_pkg::OUT_TYPE_REPL;
				osize = omt_pkg::SIZE_REPL;
			end
		endcase
		ov_new = '0;
		ov_new[1] = otype;
		ov_new[2] = osize;
		ov_new[11:4] = row_q.sym;
		ov_new[19:12] = epoch + be64(msg_q.bytes, 1);
		ov_new[27:20] = ref_key;
		case (msg_q.kind)
			omt_pkg::KIND_ADD: begin
				ov_new[28] = msg_q.bytes[17];
				ov_new[35:32] = row_q.shares;
				ov_new[43:36] = dbl;
			end
			omt_pkg::KIND_EXEC: begin
				ov_new[31:28] = be32(msg_q.bytes, 17);
				ov_new[39:32] = dbl;
			end
			omt_pkg::KIND_RED: begin
				ov_new[31:28] = row_q.shares;
			end
			default: begin
				ov_new[35:28] = row_q.key;
				ov_new[39:36] = row_q.shares;
				ov_new[47:40] = dbl;
			end
		endcase
	end

	assign load = state_q == S_SEND && (!out_v_q || xlat.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			scan_q <= '0;
			rd_v_s1 <= 1'b0;
			rd_slot_s1 <= '0;
			sent_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (issue) begin
				rd_slot_s1 <= scan_q[omt_pkg::SLOT_W-1:0];
				scan_q <= scan_q + 1'b1;
			end
			if (grow) fill_q <= fill_q + 1'b1;
			if (load) begin
				out_v_q <= 1'b1;
			end else if (xlat.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					sent_q <= '0;
					scan_q <= '0;
					if (q_pop) begin
						state_q <= q_msg.kind == omt_pkg::KIND_BAD ? S_SEND : S_SCAN;
					end
				end
				S_SCAN: begin
					if (decide) begin
						if (dec_err != omt_pkg::ST_OK) state_q <= S_SEND;
						else if (msg_q.kind == omt_pkg::KIND_RED) state_q <= S_BUILD;
						else state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (mag_q == '0 || mag_q[31]) state_q <= S_BUILD;
				end
				S_BUILD: begin
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (load) begin
						sent_q <= sent_q + 6'd1;
						if (sent_q + 6'd1 == len_q) state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) tbl_mem[wr_slot] <= wr_row;
		if (issue) rd_row_s1 <= tbl_mem[scan_q[omt_pkg::SLOT_W-1:0]];
		if (q_pop) begin
			msg_q <= q_msg;
			if (q_msg.kind == omt_pkg::KIND_BAD) begin
				ov_q <= '0;
				len_q <= 6'd1;
				err_q <= omt_pkg::ST_BAD_TYPE;
			end
		end
		if (decide) begin
			row_q <= msg_q.kind == omt_pkg::KIND_EXEC ? rd_row_s1 : wr_row;
			err_q <= dec_err;
			ov_q <= '0;
			len_q <= 6'd1;
			sign_q <= cvt_price[31];
			mag_q <= cvt_price[31] ? -cvt_price : cvt_price;
			exp_q <= 5'd31;
		end
		if (state_q == S_NORM && mag_q != '0 && !mag_q[31]) begin
			mag_q <= {mag_q[30:0], 1'b0};
			exp_q <= exp_q - 5'd1;
		end
		if (state_q == S_BUILD) begin
			ov_q <= ov_new;
			len_q <= osize[omt_pkg::CNT_W-1:0];
		end
		if (load) begin
			out_byte_q <= ov_q[0];
			out_last_q <= sent_q + 6'd1 == len_q;
			out_st_q <= err_q;
			ov_q <= {8'h00, ov_q[omt_pkg::OUT_BYTES-1:1]};
		end
	end

	assign xlat.valid = out_v_q;
	assign xlat.out_byte = out_byte_q;
	assign xlat.last = out_last_q;
	assign xlat.status = out_st_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= omt_pkg::FILL_W'(omt_pkg::ORDER_SLOTS))
		else $error("order table fill count overflow");
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_st_q != omt_pkg::ST_OK |-> out_last_q && out_byte_q == 8'h00)
		else $error("error result not a single zero byte");
	a_send_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEND |-> sent_q < len_q)
		else $error("serializer ran past message length");
endmodule
`default_nettype wire

>>> src/order_message_translator_unit.sv
// order_message_translator_unit: top level of the order message translator
// depends on omt_pkg, omt_ifs, omt_front, omt_queue and omt_back
`default_nettype none
// Takes one message byte per cycle while the two-entry queue between the message
// collector and the table engine has room. Per message the engine scans the order
// table (one entry a cycle), normalizes the price one bit a cycle except for a
// reduce or an error, then sends one output byte a cycle while the receiver is
// ready: 44, 40, 32 or 48 bytes, or one byte for an error. Table occupancy is
// tracked by a fill count, so no clearing pass follows reset.
module order_message_translator_unit (
	input wire logic  clk,
	input wire logic  arst_n,
	omt_byte_if.sink  feed,
	omt_res_if.source xlat,
	omt_cfg_if.sink   cfg
);
	logic [63:0] epoch_q;
	logic q_push;
	logic q_pop;
	omt_pkg::msg_t wr_msg;
	omt_pkg::msg_t rd_msg;
	omt_pkg::q_stat_t q_stat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q <= '0;
		end else if (cfg.valid) begin
			epoch_q <= cfg.midnight_epoch_ns;
		end
	end

	omt_front u_front (
		.clk(clk), .arst_n(arst_n), .feed(feed),
		.q_stat(q_stat), .q_push(q_push), .q_msg(wr_msg)
	);

	omt_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .wr_msg(wr_msg),
		.pop(q_pop), .rd_msg(rd_msg), .stat(q_stat)
	);

	omt_back u_back (
		.clk(clk), .arst_n(arst_n), .epoch(epoch_q), .q_stat(q_stat),
		.q_msg(rd_msg), .q_pop(q_pop), .xlat(xlat)
	);
endmodule
`default_nettype wire
